### src/tpd_pkg.sv
// shared types and constants of the telemetry packet deframer
`default_nettype none

package tpd_pkg;

   // framing bytes and telemetry frame shape
   localparam logic [7:0] StartByte = 8'd2;
   localparam logic [7:0] EndByte = 8'd3;
   localparam logic [7:0] TelemetryLength = 8'd17;
   localparam logic [7:0] TelemetryCommand = 8'd50;
   localparam logic [7:0] FieldOffset = 8'd5;
   localparam int CaptureBytes = 12;
   localparam logic [7:0] CaptureLast = FieldOffset + 8'(CaptureBytes - 1);
   localparam logic [15:0] IdleMax = 16'hFFFF;

   // item kinds
   localparam logic KindByte = 1'b0;
   localparam logic KindTick = 1'b1;

   // status codes
   localparam logic [1:0] StatusTelemetry = 2'd0;
   localparam logic [1:0] StatusGood = 2'd1;
   localparam logic [1:0] StatusCrcError = 2'd2;
   localparam logic [1:0] StatusNoEnd = 2'd3;

   // register indexes
   localparam logic [1:0] RegTimeout = 2'd0;
   localparam logic [1:0] RegMaxLength = 2'd1;
   localparam logic [1:0] RegPolynomial = 2'd2;

   // register reset values
   localparam logic [15:0] TimeoutReset = 16'd100;
   localparam logic [7:0] MaxLengthReset = 8'd63;
   localparam logic [15:0] PolynomialReset = 16'h1021;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [7:0]  max_payload_length;
      logic [15:0] crc_polynomial;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         command_code;
      logic [7:0]         payload_length;
      logic signed [15:0] switch_temp_tenths;
      logic signed [15:0] motor_temp_tenths;
      logic signed [31:0] current_hundredths;
      logic signed [31:0] speed_erpm;
   } result_type;

endpackage

`default_nettype wire

### src/tpd_crc.sv
// one byte step of the msb-first crc-16 with programmable polynomial
`default_nettype none

module tpd_crc
   import tpd_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data_byte,
   input  wire logic [15:0] polynomial,
   output logic [15:0]      crc_next
);

   // eight shift steps, one per data bit
   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ polynomial;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

`default_nettype wire

### src/tpd_parser.sv
// frame parser: phase machine, crc check, telemetry field capture
`default_nettype none

module tpd_parser
   import tpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_fire,
   input  wire logic       item_kind,
   input  wire logic [7:0] item_byte,
   input  wire cfg_type    cfg,
   output logic            result_valid,
   output result_type      result
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_CRC_HI,
      PH_CRC_LO,
      PH_END
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  byte_position_ff, byte_position_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] received_crc_ff, received_crc_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic [15:0] idle_ticks_ff, idle_ticks_in;
   logic [7:0]  capture_ff [CaptureBytes];
   logic [7:0]  capture_in [CaptureBytes];

   logic [15:0] crc_next;
   logic [7:0]  position_next;
   logic [7:0]  capture_offset;
   logic [15:0] idle_next;
   logic [1:0]  status;

   tpd_crc u_crc (
      .crc_cur    (running_crc_ff),
      .data_byte  (item_byte),
      .polynomial (cfg.crc_polynomial),
      .crc_next   (crc_next)
   );

   assign position_next = byte_position_ff + 8'd1;
   assign capture_offset = byte_position_ff - FieldOffset;
   assign idle_next = (idle_ticks_ff == IdleMax) ? idle_ticks_ff : idle_ticks_ff + 16'd1;

   // end byte verdict
   always_comb begin
      if (item_byte != EndByte) begin
         status = StatusNoEnd;
      end else if (received_crc_ff != running_crc_ff) begin
         status = StatusCrcError;
      end else if (frame_length_ff == TelemetryLength && first_byte_ff == TelemetryCommand) begin
         status = StatusTelemetry;
      end else begin
         status = StatusGood;
      end
   end

   // next state and result
   always_comb begin
      phase_in = phase_ff;
      frame_length_in = frame_length_ff;
      byte_position_in = byte_position_ff;
      running_crc_in = running_crc_ff;
      received_crc_in = received_crc_ff;
      first_byte_in = first_byte_ff;
      idle_ticks_in = idle_ticks_ff;
      capture_in = capture_ff;
      result_valid = 1'b0;
      result = '0;
      result.status = status;
      result.command_code = first_byte_ff;
      result.payload_length = frame_length_ff;
      if (status == StatusTelemetry) begin
         result.switch_temp_tenths = {capture_ff[0], capture_ff[1]};
         result.motor_temp_tenths = {capture_ff[2], capture_ff[3]};
         result.current_hundredths =
            {capture_ff[4], capture_ff[5], capture_ff[6], capture_ff[7]};
         result.speed_erpm = {capture_ff[8], capture_ff[9], capture_ff[10], capture_ff[11]};
      end
      if (item_fire && item_kind == KindTick) begin
         // idle timeout only counts inside a frame
         if (phase_ff != PH_HUNT) begin
            idle_ticks_in = idle_next;
            if (idle_next > cfg.timeout_ticks) begin
               phase_in = PH_HUNT;
            end
         end
      end else if (item_fire) begin
         idle_ticks_in = '0;
         case (phase_ff)
            PH_HUNT: begin
               if (item_byte == StartByte) begin
                  phase_in = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               if (item_byte == 8'd0 || item_byte > cfg.max_payload_length) begin
                  phase_in = PH_HUNT;
               end else begin
                  frame_length_in = item_byte;
                  byte_position_in = '0;
                  running_crc_in = '0;
                  received_crc_in = '0;
                  first_byte_in = '0;
                  for (int i = 0; i < CaptureBytes; i++) begin
                     capture_in[i] = '0;
                  end
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (byte_position_ff == 8'd0) begin
                  first_byte_in = item_byte;
               end
               if (byte_position_ff >= FieldOffset && byte_position_ff <= CaptureLast) begin
                  capture_in[capture_offset[3:0]] = item_byte;
               end
               running_crc_in = crc_next;
               byte_position_in = position_next;
               if (position_next >= frame_length_ff) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               received_crc_in = {item_byte, 8'h00};
               phase_in = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               received_crc_in = {received_crc_ff[15:8], item_byte};
               phase_in = PH_END;
            end
            PH_END: begin
               result_valid = 1'b1;
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         frame_length_ff <= '0;
         byte_position_ff <= '0;
         running_crc_ff <= '0;
         received_crc_ff <= '0;
         first_byte_ff <= '0;
         idle_ticks_ff <= '0;
         for (int i = 0; i < CaptureBytes; i++) begin
            capture_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         frame_length_ff <= frame_length_in;
         byte_position_ff <= byte_position_in;
         running_crc_ff <= running_crc_in;
         received_crc_ff <= received_crc_in;
         first_byte_ff <= first_byte_in;
         idle_ticks_ff <= idle_ticks_in;
         capture_ff <= capture_in;
      end
   end

endmodule

`default_nettype wire

### src/telemetry_packet_deframer_top.sv
// top level of the telemetry packet deframer: input, result and csr registers
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  kind, rx_byte
//   rsp      out        rsp_valid/rsp_stall  status, command, length, telemetry
//   csr      in         csr_valid/csr_ready  index, data
//
// one item per cycle while the result is not stalled: an item is held in the input
// register, the parser updates its state from it and a frame end loads the result register.
// reset clears the parser to hunting, the csr registers to their defaults and the valid bits.
// a stalled result holds; the input register still takes one item behind it.
`default_nettype none

module telemetry_packet_deframer_top
   import tpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic         req_kind,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_command_code,
   output logic [7:0]        rsp_payload_length,
   output logic signed [15:0] rsp_switch_temp_tenths,
   output logic signed [15:0] rsp_motor_temp_tenths,
   output logic signed [31:0] rsp_current_hundredths,
   output logic signed [31:0] rsp_speed_erpm,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   result_type result_ff;

   logic       out_free;
   logic       fire;
   logic       result_valid;
   result_type result;

   // handshake control
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= TimeoutReset;
         cfg_ff.max_payload_length <= MaxLengthReset;
         cfg_ff.crc_polynomial <= PolynomialReset;
      end else if (csr_valid) begin
         case (csr_index)
            RegTimeout: cfg_ff.timeout_ticks <= csr_data;
            RegMaxLength: cfg_ff.max_payload_length <= csr_data[7:0];
            RegPolynomial: cfg_ff.crc_polynomial <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_rx_byte;
      end
   end

   tpd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_fire    (fire),
      .item_kind    (in_kind_ff),
      .item_byte    (in_byte_ff),
      .cfg          (cfg_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && result_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = result_ff.status;
   assign rsp_command_code = result_ff.command_code;
   assign rsp_payload_length = result_ff.payload_length;
   assign rsp_switch_temp_tenths = result_ff.switch_temp_tenths;
   assign rsp_motor_temp_tenths = result_ff.motor_temp_tenths;
   assign rsp_current_hundredths = result_ff.current_hundredths;
   assign rsp_speed_erpm = result_ff.speed_erpm;

endmodule

`default_nettype wire
